/* design/pipc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pipc_pkg: shared types and constants for the point-in-polygon crossing core
// Holds the field width, the queue geometry and the structs that travel
// between the front end, the edge queue and the back end.
// ----------------------------------------------------------------------------
package pipc_pkg;

    localparam int FIELD_W     = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // per-item control that travels with the edge operands
    typedef struct packed {
        logic first;   // restart parity on this item
        logic last;    // emit a result after this item
        logic en_a;    // edge from previous vertex straddles the ray line
        logic en_b;    // closing edge straddles the ray line
    } t_edge_ctl;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage
`default_nettype wire

/* design/pipc_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pipc_front: vertex intake and edge classification
// Keeps the query point, the first and the previous vertex, and turns each
// accepted item into the operand differences and straddle flags of its edges.
// ----------------------------------------------------------------------------
module pipc_front #(
    parameter int CW = 32,
    parameter int DW = CW + 1
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  wire logic [pipc_pkg::FIELD_W-1:0]  i_vertex_x,
    input  wire logic [pipc_pkg::FIELD_W-1:0]  i_vertex_y,
    input  wire logic [pipc_pkg::FIELD_W-1:0]  i_point_x,
    input  wire logic [pipc_pkg::FIELD_W-1:0]  i_point_y,
    input  wire logic                          i_first,
    input  wire logic                          i_last,
    output pipc_pkg::t_edge_ctl                o_ctl,
    output logic [8*DW-1:0]                    o_data
);

    logic [CW-1:0] r_prev_x, r_prev_y, r_start_x, r_start_y, r_query_x, r_query_y;

    logic signed [DW-1:0] v_x, v_y, p_x, p_y, s_x, s_y, q_x, q_y;
    logic signed [DW-1:0] a_dx, a_dy, a_ex, a_ey, b_dx, b_dy, b_ex, b_ey;
    logic                 straddle_a, straddle_b;

    function automatic logic signed [DW-1:0] sx(input logic [CW-1:0] v);
        sx = {v[CW-1], v};
    endfunction

    assign v_x = sx(i_vertex_x[CW-1:0]);
    assign v_y = sx(i_vertex_y[CW-1:0]);
    assign p_x = sx(r_prev_x);
    assign p_y = sx(r_prev_y);
    // a first vertex brings its own query point and becomes the start
    assign q_x = i_first ? sx(i_point_x[CW-1:0]) : sx(r_query_x);
    assign q_y = i_first ? sx(i_point_y[CW-1:0]) : sx(r_query_y);
    assign s_x = i_first ? v_x : sx(r_start_x);
    assign s_y = i_first ? v_y : sx(r_start_y);

    // edge from this vertex back to the previous one
    assign a_dx = p_x - v_x;
    assign a_dy = p_y - v_y;
    assign a_ex = q_x - v_x;
    assign a_ey = q_y - v_y;
    assign straddle_a = (v_y > q_y) != (p_y > q_y);

    // closing edge from the start to this vertex
    assign b_dx = v_x - s_x;
    assign b_dy = v_y - s_y;
    assign b_ex = q_x - s_x;
    assign b_ey = q_y - s_y;
    assign straddle_b = (s_y > q_y) != (v_y > q_y);

    assign o_ctl.first = i_first;
    assign o_ctl.last  = i_last;
    assign o_ctl.en_a  = !i_first && straddle_a;
    assign o_ctl.en_b  = i_last && straddle_b;
    assign o_data = {a_dx, a_dy, a_ex, a_ey, b_dx, b_dy, b_ex, b_ey};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x  <= '0;
            r_prev_y  <= '0;
            r_start_x <= '0;
            r_start_y <= '0;
            r_query_x <= '0;
            r_query_y <= '0;
        end else if (i_accept) begin
            r_prev_x <= i_vertex_x[CW-1:0];
            r_prev_y <= i_vertex_y[CW-1:0];
            if (i_first) begin
                r_start_x <= i_vertex_x[CW-1:0];
                r_start_y <= i_vertex_y[CW-1:0];
                r_query_x <= i_point_x[CW-1:0];
                r_query_y <= i_point_y[CW-1:0];
            end
        end
    end

endmodule
`default_nettype wire

/* design/pipc_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pipc_queue: short edge queue between front and back end
// Register FIFO that lets intake and edge evaluation stall independently.
// ----------------------------------------------------------------------------
module pipc_queue #(
    parameter int DATA_W = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire logic [DATA_W-1:0]   i_data,
    input  wire logic                i_pop,
    output logic [DATA_W-1:0]        o_data,
    output pipc_pkg::t_q_status      o_status
);

    logic [DATA_W-1:0]               r_mem [pipc_pkg::QUEUE_DEPTH];
    logic [pipc_pkg::QPTR_W-1:0]     r_wr_ptr, r_rd_ptr;
    logic [pipc_pkg::QCNT_W-1:0]     r_count;
    logic [pipc_pkg::QPTR_W-1:0]     n_wr_ptr, n_rd_ptr;

    localparam logic [pipc_pkg::QPTR_W-1:0] LastSlot =
        pipc_pkg::QPTR_W'(pipc_pkg::QUEUE_DEPTH - 1);

    assign n_wr_ptr = (r_wr_ptr == LastSlot) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == LastSlot) ? '0 : r_rd_ptr + 1'b1;

    assign o_data          = r_mem[r_rd_ptr];
    assign o_status.full   = (r_count == pipc_pkg::QCNT_W'(pipc_pkg::QUEUE_DEPTH));
    assign o_status.empty  = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

/* design/pipc_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pipc_back: crossing evaluation and parity
// Forms the cross products of both edges in a register stage, then compares
// them, updates the parity and loads the result register on a last vertex.
// ----------------------------------------------------------------------------
module pipc_back #(
    parameter int DW = 33,
    parameter int PW = 2 * DW
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire pipc_pkg::t_edge_ctl   i_ctl,
    input  wire logic [8*DW-1:0]       i_data,
    output logic                       o_pop,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic                       o_inside
);

    logic signed [DW-1:0] a_dx, a_dy, a_ex, a_ey, b_dx, b_dy, b_ex, b_ey;

    logic                 r_m_valid;
    pipc_pkg::t_edge_ctl  r_m_ctl;
    logic signed [PW-1:0] r_lhs_a, r_rhs_a, r_lhs_b, r_rhs_b;
    logic                 r_neg_a, r_neg_b;
    logic                 r_parity;
    logic                 r_out_valid, r_out_res;

    logic                 m_consume, cnt_a, cnt_b, n_parity;

    function automatic logic signed [PW-1:0] mul(input logic signed [DW-1:0] a,
                                                 input logic signed [DW-1:0] b);
        logic signed [PW-1:0] aw, bw;
        aw  = PW'(a);
        bw  = PW'(b);
        mul = aw * bw;
    endfunction

    assign {a_dx, a_dy, a_ex, a_ey, b_dx, b_dy, b_ex, b_ey} = i_data;

    // a non-last item never needs the result register
    assign m_consume = r_m_valid && (!r_m_ctl.last || !r_out_valid || i_ready);
    assign o_pop     = i_valid && (!r_m_valid || m_consume);

    // compare direction follows the sign of the edge's y difference
    assign cnt_a = r_m_ctl.en_a && (r_neg_a ? (r_lhs_a > r_rhs_a) : (r_lhs_a < r_rhs_a));
    assign cnt_b = r_m_ctl.en_b && (r_neg_b ? (r_lhs_b > r_rhs_b) : (r_lhs_b < r_rhs_b));
    assign n_parity = (r_m_ctl.first ? 1'b0 : r_parity) ^ cnt_a ^ cnt_b;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_m_ctl <= i_ctl;
            r_lhs_a <= mul(a_ex, a_dy);
            r_rhs_a <= mul(a_dx, a_ey);
            r_lhs_b <= mul(b_ex, b_dy);
            r_rhs_b <= mul(b_dx, b_ey);
            r_neg_a <= a_dy[DW-1];
            r_neg_b <= b_dy[DW-1];
        end
        if (m_consume && r_m_ctl.last) begin
            r_out_res <= n_parity;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid   <= 1'b0;
            r_parity    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_m_valid <= 1'b1;
            end else if (m_consume) begin
                r_m_valid <= 1'b0;
            end
            if (m_consume) begin
                r_parity <= n_parity;
            end
            if (m_consume && r_m_ctl.last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_inside = r_out_res;

endmodule
`default_nettype wire

/* design/point_in_polygon_crossing_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// point_in_polygon_crossing_core: even-odd point-in-polygon test
// Streams polygon vertices in and returns one inside flag per polygon.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one vertex per item. tdata carries vertex_x, vertex_y,
//   point_x, point_y (32 bits each, signed Q16.16); tuser marks the first
//   vertex, which also latches the query point; tlast marks the last vertex,
//   which closes the polygon and yields a result.
//   Master channel: one item per last vertex, tdata bit 0 is the inside flag.
//   Throughput: one vertex per cycle while the edge queue is not full; the
//   path runs difference and classify at intake, products, then compare and
//   parity, via the edge queue and product register into the result register.
//   Stalls: a stalled master holds the result register; the back end keeps
//   consuming vertices that yield no result, and the two-entry edge queue
//   drops o_s_tready only once it fills.
//   Reset: query point, first and previous vertex all return to the origin
//   and the parity to zero; no item is held.
// ----------------------------------------------------------------------------
module point_in_polygon_crossing_core #(
    parameter int COORD_WIDTH = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire logic [127:0]  i_s_tdata,   // vertex_x, vertex_y, point_x, point_y
    input  wire logic          i_s_tuser,   // first_vertex
    input  wire logic          i_s_tlast,   // last_vertex
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    output logic [7:0]         o_m_tdata    // inside_res, zero fill
);

    localparam int CW     = (COORD_WIDTH < pipc_pkg::FIELD_W) ? COORD_WIDTH
                                                               : pipc_pkg::FIELD_W;
    localparam int DW     = CW + 1;
    localparam int CTL_W  = $bits(pipc_pkg::t_edge_ctl);
    localparam int DATA_W = CTL_W + 8 * DW;

    localparam int FW = pipc_pkg::FIELD_W;

    logic                 s_accept, q_pop, res_inside;
    pipc_pkg::t_edge_ctl  f_ctl, b_ctl;
    logic [8*DW-1:0]      f_data, b_data;
    logic [DATA_W-1:0]    q_rd;
    pipc_pkg::t_q_status  q_status;

    assign o_s_tready = !q_status.full;
    assign s_accept   = i_s_tvalid && o_s_tready;

    pipc_front #(.CW(CW), .DW(DW)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (s_accept),
        .i_vertex_x (i_s_tdata[FW-1:0]),
        .i_vertex_y (i_s_tdata[2*FW-1:FW]),
        .i_point_x  (i_s_tdata[3*FW-1:2*FW]),
        .i_point_y  (i_s_tdata[4*FW-1:3*FW]),
        .i_first    (i_s_tuser),
        .i_last     (i_s_tlast),
        .o_ctl      (f_ctl),
        .o_data     (f_data)
    );

    pipc_queue #(.DATA_W(DATA_W)) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (s_accept),
        .i_data   ({f_ctl, f_data}),
        .i_pop    (q_pop),
        .o_data   (q_rd),
        .o_status (q_status)
    );

    assign b_ctl  = q_rd[DATA_W-1:8*DW];
    assign b_data = q_rd[8*DW-1:0];

    pipc_back #(.DW(DW)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (!q_status.empty),
        .i_ctl    (b_ctl),
        .i_data   (b_data),
        .o_pop    (q_pop),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_inside (res_inside)
    );

    assign o_m_tdata = {7'b0, res_inside};

`ifndef SYNTHESIS
    a_queue_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty))
        else $error("edge queue reports full and empty together");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_status.empty)
        else $error("back end popped an empty edge queue");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_status.full && !q_pop) |=> (q_status.full || !$past(s_accept)))
        else $error("item accepted while edge queue full");
`endif

endmodule
`default_nettype wire

/* tb/point_in_polygon_crossing_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_crossing_core_tb: self-checking bench for the crossing core
// Streams polygons vertex by vertex through a bursty source into the core.
// A stalling sink takes the results. Each inside flag is compared with a
// local even-odd predictor, or with a row's hand-written result where it
// carries one. That predictor uses exact cross-multiplied edge tests.
// ----------------------------------------------------------------------------
module point_in_polygon_crossing_core_tb;

    localparam int                 CYCLE_LIMIT  = 200000;
    localparam int                 RANDOM_ITEMS = 450;
    localparam logic signed [31:0] ONE          = 32'sh0001_0000;
    localparam logic signed [31:0] MAXV         = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MINV         = 32'sh8000_0000;

    typedef enum logic [1:0] {COORD_TINY, COORD_GRID, COORD_WIDE, COORD_EDGE} t_coord_style;
    typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_CHOKE, SINK_LEAKY} t_sink_style;

    typedef struct {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] px;
        logic signed [31:0] py;
        bit                 first;
        bit                 last;
        bit                 has_want;  // row carries a hand-written result
        bit                 want;
    } t_vertex_item;

    logic         i_clk      = 1'b0;
    logic         i_rst_n    = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [127:0] i_s_tdata  = '0;   // vertex_x, vertex_y, point_x, point_y
    logic         i_s_tuser  = 1'b0; // first_vertex
    logic         i_s_tlast  = 1'b0; // last_vertex
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [7:0]   o_m_tdata;         // inside_res, zero fill

    point_in_polygon_crossing_core #(
        .COORD_WIDTH(32)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic signed [31:0] last_x = '0, last_y = '0;
    logic signed [31:0] origin_x = '0, origin_y = '0;
    logic signed [31:0] probe_x = '0, probe_y = '0;
    bit                 crossings_odd = 1'b0;

    bit           inside_due[$];
    t_vertex_item stimulus_rows[$];
    int           fail_count = 0;
    int           cycle_count = 0;
    int           burst_left = 0;
    int           items_sent = 0;

    // Edge counts when it straddles the probe's line and crosses strictly right.
    function automatic bit ray_crosses_edge(input logic signed [31:0] xi, yi, xj, yj);
        logic signed [32:0] dx, dy, ex, ey;
        logic signed [65:0] lhs, rhs;
        if ((yi > probe_y) == (yj > probe_y))
            return 1'b0;
        dx  = xj - xi;
        dy  = yj - yi;
        ex  = probe_x - xi;
        ey  = probe_y - yi;
        lhs = ex * dy;
        rhs = dx * ey;
        return (dy > 0) ? (lhs < rhs) : (lhs > rhs);
    endfunction

    function automatic void advance_parity(input t_vertex_item v, output bit emits,
                                           output bit is_in);
        if (v.first) begin
            probe_x       = v.px;
            probe_y       = v.py;
            origin_x      = v.vx;
            origin_y      = v.vy;
            crossings_odd = 1'b0;
        end else if (ray_crosses_edge(v.vx, v.vy, last_x, last_y)) begin
            crossings_odd = !crossings_odd;
        end
        last_x = v.vx;
        last_y = v.vy;
        emits  = v.last;
        if (v.last && ray_crosses_edge(origin_x, origin_y, v.vx, v.vy))
            crossings_odd = !crossings_odd;
        is_in = crossings_odd;
    endfunction

    function automatic logic signed [31:0] pick_coord(input t_coord_style style);
        case (style)
            COORD_TINY: return int'($urandom_range(0, 8)) - 4;
            COORD_GRID: return (int'($urandom_range(0, 40)) - 20) * ONE;
            COORD_WIDE: return $urandom;
            default: begin
                case ($urandom_range(0, 6))
                    0:       return MINV;
                    1:       return MAXV;
                    2:       return MINV + 1;
                    3:       return MAXV - 1;
                    4:       return -1;
                    5:       return 1;
                    default: return 0;
                endcase
            end
        endcase
    endfunction

    task automatic add_row(input logic signed [31:0] vx, vy, px, py, input bit first, last,
                           input bit has_want, want);
        t_vertex_item r;
        r = '{vx, vy, px, py, first, last, has_want, want};
        stimulus_rows = {stimulus_rows, r};
    endtask

    task automatic send_vertex(input t_vertex_item v);
        bit emits, is_in;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {v.py, v.px, v.vy, v.vx};
        i_s_tuser  <= v.first;
        i_s_tlast  <= v.last;
        do @(posedge i_clk); while (!o_s_tready);
        items_sent++;
        advance_parity(v, emits, is_in);
        if (emits)
            inside_due = {inside_due, (v.has_want ? v.want : is_in)};
    endtask

    // Source pacing: bursts of items with idle gaps in between.
    task automatic pace_source();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 16);
            gap = $urandom_range(0, 7);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_polygon();
        t_vertex_item       v;
        logic signed [31:0] xs[8], ys[8];
        t_coord_style       style;
        int                 n;
        bit                 noisy, mixed;
        n     = $urandom_range(0, 9) == 0 ? $urandom_range(1, 2) : $urandom_range(3, 8);
        style = t_coord_style'($urandom_range(0, 3));
        noisy = $urandom_range(0, 9) == 0;
        mixed = $urandom_range(0, 7) == 0;
        for (int k = 0; k < n; k++) begin
            xs[k] = pick_coord(mixed ? t_coord_style'($urandom_range(0, 3)) : style);
            ys[k] = pick_coord(mixed ? t_coord_style'($urandom_range(0, 3)) : style);
        end
        for (int k = 0; k < n; k++) begin
            v.vx       = xs[k];
            v.vy       = ys[k];
            v.px       = $urandom;
            v.py       = $urandom;
            v.has_want = 1'b0;
            v.want     = 1'b0;
            if (k == 0) begin
                // put the probe on a vertex's lines now and then
                if ($urandom_range(0, 1) == 0) begin
                    v.px = pick_coord(style);
                    v.py = pick_coord(style);
                end else begin
                    v.px = xs[$urandom_range(0, n - 1)];
                    v.py = ys[$urandom_range(0, n - 1)];
                end
            end
            if (noisy) begin
                v.first = $urandom_range(0, 3) == 0;
                v.last  = $urandom_range(0, 3) == 0;
            end else begin
                v.first = (k == 0);
                v.last  = (k == n - 1);
            end
            send_vertex(v);
            pace_source();
        end
    endtask

    // Sink: ready follows a stall style that is redrawn each time sink_tick wraps.
    logic [5:0]  sink_tick  = '0;
    t_sink_style sink_style = SINK_OPEN;

    always @(posedge i_clk) begin
        sink_tick <= sink_tick + 1'b1;
        if (sink_tick == '0)
            sink_style <= t_sink_style'($urandom_range(0, 3));
        case (sink_style)
            SINK_OPEN:  i_m_tready <= 1'b1;
            SINK_COIN:  i_m_tready <= 1'($urandom_range(0, 1));
            SINK_CHOKE: i_m_tready <= (sink_tick[3:0] < 4'd4);
            default:    i_m_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (o_m_tvalid && i_m_tready) begin
            if (inside_due.size() == 0) begin
                $error("inside_res: no result expected, got %0b", o_m_tdata[0]);
                fail_count++;
            end else begin
                if (o_m_tdata[0] !== inside_due[0]) begin
                    $error("inside_res: expected %0b, got %0b", inside_due[0], o_m_tdata[0]);
                    fail_count++;
                end
                if (o_m_tdata[7:1] !== 7'd0) begin
                    $error("tdata fill: expected %0h, got %0h", 7'd0, o_m_tdata[7:1]);
                    fail_count++;
                end
                void'(inside_due.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        // vertex before any first vertex: continues from the origin state
        add_row( 3 * ONE,  5 * ONE, MAXV, MINV, 1'b0, 1'b1, 1'b0, 1'b0);
        // single-vertex polygon at the extremes
        add_row(MAXV, MINV, MINV, MAXV, 1'b1, 1'b1, 1'b1, 1'b0);
        // square around the probe
        add_row(-10 * ONE, -10 * ONE, 0, 0, 1'b1, 1'b0, 1'b0, 1'b0);
        add_row( 10 * ONE, -10 * ONE, MAXV, MAXV, 1'b0, 1'b0, 1'b0, 1'b0);
        add_row( 10 * ONE,  10 * ONE, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0);
        add_row(-10 * ONE,  10 * ONE, 0, 0, 1'b0, 1'b1, 1'b0, 1'b0);
        // probe exactly on the right edge and then on a vertex
        add_row(-10 * ONE, -10 * ONE, 10 * ONE, 0, 1'b1, 1'b0, 1'b0, 1'b0);
        add_row( 10 * ONE, -10 * ONE, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0);
        add_row( 10 * ONE,  10 * ONE, 0, 0, 1'b0, 1'b1, 1'b0, 1'b0);
        add_row(-10 * ONE, 10 * ONE, 10 * ONE, 10 * ONE, 1'b1, 1'b0, 1'b0, 1'b0);
        add_row( 10 * ONE, 10 * ONE, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0);
        add_row(  0,      -10 * ONE, 0, 0, 1'b0, 1'b1, 1'b0, 1'b0);
        // horizontal edge on the probe's line
        add_row(-5 * ONE, 0, -10 * ONE, 0, 1'b1, 1'b0, 1'b0, 1'b0);
        add_row( 5 * ONE, 0, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0);
        add_row( 0, 5 * ONE, 0, 0, 1'b0, 1'b1, 1'b0, 1'b0);
        // carry on past a last vertex without a new first vertex
        add_row(20 * ONE, -20 * ONE, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0);
        add_row(20 * ONE,  20 * ONE, 0, 0, 1'b0, 1'b1, 1'b0, 1'b0);
        // full-range square: differences overflow 32 bits
        add_row(MINV, MINV, -1, -1, 1'b1, 1'b0, 1'b0, 1'b0);
        add_row(MAXV, MINV, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0);
        add_row(MAXV, MAXV, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0);
        add_row(MINV, MAXV, 0, 0, 1'b0, 1'b1, 1'b0, 1'b0);
        // thin sliver with the probe at the far corner of the range
        add_row(MINV, MAXV, MAXV - 1, MINV + 1, 1'b1, 1'b0, 1'b0, 1'b0);
        add_row(MAXV, MINV, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0);
        add_row(MAXV, MINV + 2, 0, 0, 1'b0, 1'b1, 1'b0, 1'b0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stimulus_rows[k]) begin
            send_vertex(stimulus_rows[k]);
            pace_source();
        end

        while (items_sent < RANDOM_ITEMS)
            send_polygon();

        i_s_tvalid <= 1'b0;
        while (inside_due.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
